@@ src/api_frame_rx_deframer_assert.svh @@
// Assertion macros for the API frame deframer.
// Depends on nothing; included by the top level.
`ifndef API_FRAME_RX_DEFRAMER_ASSERT_SVH
`define API_FRAME_RX_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/afd_pkg.sv @@
// Package for the API frame deframer: byte codes, kind codes, result type.
// Depends on nothing.
`timescale 1ns / 1ps

package afd_pkg;

  // Framing bytes and checksum base.
  localparam logic [7:0] Delim   = 8'h7E;
  localparam logic [7:0] Esc     = 8'h7D;
  localparam logic [7:0] EscXor  = 8'h20;
  localparam logic [7:0] SumBase = 8'hFF;

  // Result kinds.
  localparam logic [1:0] KindBody  = 2'd0;
  localparam logic [1:0] KindEnd   = 2'd1;
  localparam logic [1:0] KindAbort = 2'd2;

  // One result item.
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  body_byte;
    logic        is_frame_type;
    logic        checksum_ok;
    logic [15:0] frame_length;
  } afd_result_t;

endpackage

@@ src/afd_if.sv @@
// Valid/ready channel interfaces for the API frame deframer.
// Depends on nothing.
`timescale 1ns / 1ps

// Raw received byte channel.
interface afd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Deframed result channel.
interface afd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [7:0]  body_byte;
  logic        is_frame_type;
  logic        checksum_ok;
  logic [15:0] frame_length;

  modport source (output valid, output item_kind, output body_byte,
                  output is_frame_type, output checksum_ok, output frame_length,
                  input ready);
  modport sink (input valid, input item_kind, input body_byte,
                input is_frame_type, input checksum_ok, input frame_length,
                output ready);
endinterface

@@ src/afd_in_stage.sv @@
// Input register of the API frame deframer: holds one raw byte for the core.
// Depends on nothing.
`timescale 1ns / 1ps

module afd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  input  logic       advance_i,
  output logic       ready_o,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // The register takes a new item when empty or when its item moves on.
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ src/afd_core.sv @@
// Frame state and per-byte decode of the API frame deframer.
// Depends on afd_pkg.
`timescale 1ns / 1ps

module afd_core
  import afd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  output afd_result_t res_o
);

  // Phase codes.
  localparam logic [1:0] PhHunt  = 2'd0;
  localparam logic [1:0] PhLenHi = 2'd1;
  localparam logic [1:0] PhLenLo = 2'd2;
  localparam logic [1:0] PhData  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;
  logic [7:0]  sum_q, sum_d;

  logic [7:0]  data_byte;

  // Unescape: a byte that follows the escape is XORed back to its data value.
  always_comb begin
    data_byte = esc_q ? (rx_byte_i ^ EscXor) : rx_byte_i;
  end

  // Next state and result for the current item.
  always_comb begin
    phase_d     = phase_q;
    esc_d       = esc_q;
    len_d       = len_q;
    seen_d      = seen_q;
    sum_d       = sum_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_q)
      PhHunt: begin
        if (rx_byte_i == Delim) begin
          phase_d = PhLenHi;
          esc_d   = 1'b0;
          len_d   = '0;
          seen_d  = '0;
          sum_d   = '0;
        end
      end
      default: begin
        if (!esc_q && (rx_byte_i == Delim)) begin
          // Unescaped delimiter inside a frame: abort and restart.
          res_valid_o     = 1'b1;
          res_o.item_kind = KindAbort;
          phase_d         = PhLenHi;
          esc_d           = 1'b0;
          len_d           = '0;
          seen_d          = '0;
          sum_d           = '0;
        end else if (!esc_q && (rx_byte_i == Esc)) begin
          esc_d = 1'b1;
        end else begin
          esc_d = 1'b0;
          case (phase_q)
            PhLenHi: begin
              len_d   = {data_byte, 8'h00};
              phase_d = PhLenLo;
            end
            PhLenLo: begin
              len_d   = {len_q[15:8], data_byte};
              seen_d  = '0;
              sum_d   = '0;
              phase_d = PhData;
            end
            default: begin
              res_valid_o        = 1'b1;
              res_o.frame_length = len_q;
              if (seen_q < len_q) begin
                // Body byte.
                res_o.item_kind     = KindBody;
                res_o.body_byte     = data_byte;
                res_o.is_frame_type = (seen_q == 16'd0);
                sum_d               = sum_q + data_byte;
                seen_d              = seen_q + 16'd1;
              end else begin
                // Checksum byte: report and go back to hunting.
                res_o.item_kind   = KindEnd;
                res_o.checksum_ok = ((SumBase - sum_q) == data_byte);
                phase_d           = PhHunt;
                esc_d             = 1'b0;
                len_d             = '0;
                seen_d            = '0;
                sum_d             = '0;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      esc_q   <= 1'b0;
      len_q   <= '0;
      seen_q  <= '0;
      sum_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      sum_q   <= sum_d;
    end
  end

endmodule

@@ src/afd_out_stage.sv @@
// Result register of the API frame deframer, driving the result channel.
// Depends on afd_pkg and afd_if.
`timescale 1ns / 1ps

module afd_out_stage
  import afd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  afd_result_t res_i,
  output logic        free_o,
  afd_res_if.source   out_o
);

  logic        valid_q, valid_d;
  afd_result_t res_q;

  // Free when empty or when the held item leaves in this cycle.
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.item_kind     = res_q.item_kind;
  assign out_o.body_byte     = res_q.body_byte;
  assign out_o.is_frame_type = res_q.is_frame_type;
  assign out_o.checksum_ok   = res_q.checksum_ok;
  assign out_o.frame_length  = res_q.frame_length;

endmodule

@@ src/api_frame_rx_deframer.sv @@
// API frame deframer: takes escaped raw bytes and emits body, end and abort items.
// The block takes one raw byte per item on in_i (valid/ready) and gives at most one
// result item per byte on out_o (valid/ready). Bytes outside a frame, the escape
// byte and the length bytes give no result. Each body byte gives a body item,
// the checksum byte gives an end item with checksum_ok, and an unescaped
// delimiter inside a frame gives an abort item and starts a new frame.
// A byte accepted on in_i is held in the input register, is decoded from there when
// the result register is free, and its result is presented on out_o from the
// result register.
// Throughput: one byte per cycle while out_o does not stall; the frame state
// (phase, escape flag, length, count and 8-bit sum) updates through an 8-bit add
// and a 16-bit compare between the input register and the result register.
// Reset (rst_ni low, asynchronous) empties both registers and puts the block
// in delimiter hunt with cleared counters.
// When the receiver stalls, the result is held in the output register; the
// next byte still enters the input register and waits there, and in_i.ready
// drops only when both registers are full.
// Depends on afd_pkg, afd_if, afd_in_stage, afd_core, afd_out_stage and the
// assertion header.
`timescale 1ns / 1ps
`include "api_frame_rx_deframer_assert.svh"

module api_frame_rx_deframer
  import afd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  afd_rx_if.sink    in_i,
  afd_res_if.source out_o
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_fire;
  logic        out_free;
  logic        res_valid;
  afd_result_t res;

  // A held byte is decoded whenever the result register can take its result.
  assign s1_fire = s1_valid && out_free;

  afd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .byte_i    (in_i.rx_byte),
    .advance_i (s1_fire),
    .ready_o   (in_i.ready),
    .valid_o   (s1_valid),
    .byte_o    (s1_byte)
  );

  afd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_fire),
    .rx_byte_i   (s1_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  afd_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (s1_fire && res_valid),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

  // Checks on the block's own logic.
  `AFD_ASSERT_IMPLIES(a_abort_clean, clk_i, rst_ni, out_o.valid && (out_o.item_kind == KindAbort), (out_o.frame_length == 16'd0) && (out_o.body_byte == 8'd0), "abort item carries data")
  `AFD_ASSERT_IMPLIES(a_body_len, clk_i, rst_ni, out_o.valid && (out_o.item_kind == KindBody), (out_o.frame_length != 16'd0) && !out_o.checksum_ok, "body item in empty frame")
  `AFD_ASSERT_IMPLIES(a_type_flag, clk_i, rst_ni, out_o.valid && out_o.is_frame_type, out_o.item_kind == KindBody, "frame type flag on non-body item")
  `AFD_ASSERT_NEXT(a_in_held, clk_i, rst_ni, in_i.valid && in_i.ready, s1_valid, "accepted byte lost")

endmodule
